@@ hw/rtl/segment_feature_normalizer_top_assert.svh @@
// Assertion macros for the segment feature normalizer RTL.
// Included by the top module for its concurrent checks; needs nothing else.
`ifndef SEGMENT_FEATURE_NORMALIZER_TOP_ASSERT_SVH
`define SEGMENT_FEATURE_NORMALIZER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFN_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sfn: same-cycle check failed");
`define SFN_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sfn: next-cycle check failed");
`else
`define SFN_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define SFN_ASSERT_NXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

@@ hw/rtl/sfn_pkg.sv @@
// Shared constants and types for the segment feature normalizer.
// No dependencies.
`default_nettype none
package sfn_pkg;
  localparam int DIV_W    = 32;   // divisor width (duration, scales)
  localparam int TQ_W     = 45;   // time quotient bits, enough to pass the clamp
  localparam int SQ_W     = 19;   // tanh argument bits, Q16.16 below 8.0
  localparam int TANH_LAT = 4;    // interpolation stages
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [TQ_W-1:0] TIME_CLAMP = TQ_W'(1) << 44;
  localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    REG_BIN_MS      = 3'd0,
    REG_DURATION_MS = 3'd1,
    REG_SCORE_SCALE = 3'd2,
    REG_MAG_SCALE   = 3'd3,
    REG_TIME_WEIGHT = 3'd4,
    REG_SCORE_WEIGHT = 3'd5,
    REG_MAG_WEIGHT  = 3'd6
  } sfn_reg_t;
endpackage
`default_nettype wire

@@ hw/rtl/segment_feature_normalizer_top.sv @@
// Segment feature normalizer: scored segment in, weighted 3-D point out.
// Depends on sfn_pkg, sfn_div, sfn_tanh and the assertion macro header.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      segment: open bin, score, global z, number
//  m_*       out  tvalid/tready      point: time, score, magnitude coords, index
//  APB       in   psel/penable/..    seven configuration registers at 4*i
//
// One item enters per cycle while s_tready is high; m_tvalid follows the path of
// the 45-bit time quotient, built one bit per stage, then the weighting registers.
// A stall on m_tready freezes the whole pipeline; s_tready drops only while a
// finished point sits unread on the output. Reset clears valid bits and loads
// register defaults; no clearing pass. Write configuration only when idle.
`default_nettype none
`include "segment_feature_normalizer_top_assert.svh"
module segment_feature_normalizer_top #(
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int INDEX_WIDTH      = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // open_bin[23:0] score[55:24] global_z[87:56]
                                  // point_number[103:88]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // time_coord[31:0] score_coord[63:32]
                                  // magnitude_coord[95:64] point_index[111:96]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import sfn_pkg::*;

  localparam int TDIV_LAT = TQ_W + 1;
  localparam int SDIV_LAT = SQ_W + 1;
  localparam int SKEW     = TDIV_LAT - SDIV_LAT - TANH_LAT;  // tanh inputs wait
  localparam int NEG_DLY  = SKEW + SDIV_LAT;
  localparam int OUT_DLY  = TDIV_LAT + 2;                     // two weighting stages
  localparam logic [15:0] IDX_KEEP =
    (INDEX_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << INDEX_WIDTH) - 32'd1);

  // configuration
  logic [15:0]        bin_ms;
  logic [31:0]        duration_ms, score_scale, magnitude_scale;
  logic signed [15:0] time_weight, score_weight, magnitude_weight;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_ms           <= 16'd100;
      duration_ms      <= 32'd1000;
      score_scale      <= 32'd65536;
      magnitude_scale  <= 32'd65536;
      time_weight      <= 16'sd4096;
      score_weight     <= 16'sd4096;
      magnitude_weight <= 16'sd4096;
    end else if (psel && penable && pwrite) begin
      case (sfn_reg_t'(paddr[4:2]))
        REG_BIN_MS:       bin_ms           <= pwdata[15:0];
        REG_DURATION_MS:  duration_ms      <= pwdata;
        REG_SCORE_SCALE:  score_scale      <= pwdata;
        REG_MAG_SCALE:    magnitude_scale  <= pwdata;
        REG_TIME_WEIGHT:  time_weight      <= pwdata[15:0];
        REG_SCORE_WEIGHT: score_weight     <= pwdata[15:0];
        REG_MAG_WEIGHT:   magnitude_weight <= pwdata[15:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (sfn_reg_t'(paddr[4:2]))
      REG_BIN_MS:       prdata = {16'd0, bin_ms};
      REG_DURATION_MS:  prdata = duration_ms;
      REG_SCORE_SCALE:  prdata = score_scale;
      REG_MAG_SCALE:    prdata = magnitude_scale;
      REG_TIME_WEIGHT:  prdata = {16'd0, time_weight};
      REG_SCORE_WEIGHT: prdata = {16'd0, score_weight};
      REG_MAG_WEIGHT:   prdata = {16'd0, magnitude_weight};
      default:          prdata = '0;
    endcase
  end

  // divisors floored at one LSB
  logic [31:0] dur_div, ss_div, ms_div;
  assign dur_div = (duration_ms == '0) ? 32'd1 : duration_ms;
  assign ss_div  = (score_scale == '0) ? 32'd1 : score_scale;
  assign ms_div  = (magnitude_scale == '0) ? 32'd1 : magnitude_scale;

  // global advance: hold everything while the output transaction stalls
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage
  logic [23:0]        in_start;
  logic signed [31:0] in_score, in_z;
  logic [15:0]        in_pnum;
  assign in_start = s_tdata[23:0];
  assign in_score = s_tdata[55:24];
  assign in_z     = s_tdata[87:56];
  assign in_pnum  = s_tdata[103:88];

  logic        v_a;
  logic [39:0] a_num;
  logic [31:0] a_smag, a_zmag;
  logic        a_neg;
  logic [15:0] a_idx;

  logic        v_line   [OUT_DLY];
  logic [15:0] idx_line [OUT_DLY];
  logic [31:0] smag_dly [SKEW];
  logic [31:0] zmag_dly [SKEW];
  logic        neg_dly  [NEG_DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      for (int k = 0; k < OUT_DLY; k++) v_line[k] <= 1'b0;
    end else if (en) begin
      v_a       <= s_tvalid;
      v_line[0] <= v_a;
      for (int k = 1; k < OUT_DLY; k++) v_line[k] <= v_line[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num  <= 40'(in_start) * 40'(bin_ms);
      a_smag <= in_score[31] ? 32'(-in_score) : in_score;
      a_zmag <= in_z[31] ? 32'(-in_z) : in_z;
      a_neg  <= in_score[31];
      a_idx  <= in_pnum & IDX_KEEP;
      idx_line[0] <= a_idx;
      for (int k = 1; k < OUT_DLY; k++) idx_line[k] <= idx_line[k-1];
      smag_dly[0] <= a_smag;
      zmag_dly[0] <= a_zmag;
      for (int k = 1; k < SKEW; k++) begin
        smag_dly[k] <= smag_dly[k-1];
        zmag_dly[k] <= zmag_dly[k-1];
      end
      neg_dly[0] <= a_neg;
      for (int k = 1; k < NEG_DLY; k++) neg_dly[k] <= neg_dly[k-1];
    end
  end

  // time: open_bin*bin_ms*2^16 / duration
  logic [TQ_W-1:0] t_quo;
  logic            t_ovf;
  sfn_div #(.NUM_W(56), .QUO_W(TQ_W)) u_tdiv (
    .clk(clk), .en(en), .dividend({a_num, 16'd0}), .divisor(dur_div),
    .quo(t_quo), .ovf(t_ovf)
  );

  // tanh arguments: |v|*2^16 / scale, flagged when 8.0 or more
  logic [SQ_W-1:0] s_quo, z_quo;
  logic            s_ovf, z_ovf;
  sfn_div #(.NUM_W(48), .QUO_W(SQ_W)) u_sdiv (
    .clk(clk), .en(en), .dividend({smag_dly[SKEW-1], 16'd0}), .divisor(ss_div),
    .quo(s_quo), .ovf(s_ovf)
  );
  sfn_div #(.NUM_W(48), .QUO_W(SQ_W)) u_zdiv (
    .clk(clk), .en(en), .dividend({zmag_dly[SKEW-1], 16'd0}), .divisor(ms_div),
    .quo(z_quo), .ovf(z_ovf)
  );

  logic signed [17:0] s_tanh, z_tanh;
  sfn_tanh #(.DEPTH(TANH_TABLE_DEPTH)) u_stanh (
    .clk(clk), .en(en), .quo(s_quo), .ovf(s_ovf), .neg(neg_dly[NEG_DLY-1]),
    .coord(s_tanh)
  );
  sfn_tanh #(.DEPTH(TANH_TABLE_DEPTH)) u_ztanh (
    .clk(clk), .en(en), .quo(z_quo), .ovf(z_ovf), .neg(1'b0), .coord(z_tanh)
  );

  // clamp time at 2^44; beyond that every nonzero weight saturates anyway
  logic [TQ_W-1:0] t_c;
  assign t_c = (t_ovf || (t_quo > TIME_CLAMP)) ? TIME_CLAMP : t_quo;

  function automatic logic [31:0] sat32(input logic signed [61:0] p);
    logic signed [49:0] q;
    q = p[61:12];  // arithmetic shift: floor of p/4096
    if (q > 50'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    else if (q < -50'sh8000_0000) return 32'h8000_0000;
    else return q[31:0];
  endfunction

  logic signed [61:0] w_prod [3];
  logic [31:0]        o_time, o_score, o_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      w_prod[0] <= 62'($signed({1'b0, t_c}) * time_weight);
      w_prod[1] <= 62'(s_tanh * score_weight);
      w_prod[2] <= 62'(z_tanh * magnitude_weight);
      o_time    <= sat32(w_prod[0]);
      o_score   <= sat32(w_prod[1]);
      o_mag     <= sat32(w_prod[2]);
    end
  end

  assign m_tvalid = v_line[OUT_DLY-1];
  assign m_tdata  = {idx_line[OUT_DLY-1], o_mag, o_score, o_time};

  `SFN_ASSERT_NXT(a_accept_enters, clk, rst, s_tvalid && s_tready, v_a)
  `SFN_ASSERT_NXT(a_stall_holds, clk, rst, !s_tready, $stable(v_a))
  `SFN_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)
  `SFN_ASSERT_IMP(a_zero_time_weight, clk, rst, m_tvalid && (time_weight == 16'sd0),
                  m_tdata[31:0] == 32'd0)
endmodule
`default_nettype wire

@@ hw/rtl/sfn_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sfn_pkg.
`default_nettype none
module sfn_div #(
  parameter int NUM_W = 56,
  parameter int QUO_W = 45
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [NUM_W-1:0]          dividend,
  input  logic [sfn_pkg::DIV_W-1:0] divisor,
  output logic [QUO_W-1:0]          quo,
  output logic                      ovf
);
  import sfn_pkg::*;

  logic [DIV_W-1:0] rem      [QUO_W+1];
  logic [DIV_W-1:0] rem_next [QUO_W+1];
  logic [QUO_W-1:0] low      [QUO_W+1];
  logic [QUO_W-1:0] low_next [QUO_W+1];
  logic [QUO_W-1:0] qb       [QUO_W+1];
  logic [QUO_W-1:0] qb_next  [QUO_W+1];
  logic             ovb      [QUO_W+1];
  logic             ovb_next [QUO_W+1];

  always_comb begin
    logic [DIV_W-1:0] hi;
    logic [DIV_W:0]   trial;
    hi = DIV_W'(dividend[NUM_W-1:QUO_W]);
    // quotient does not fit: flag it and start from zero
    ovb_next[0] = (hi >= divisor);
    rem_next[0] = ovb_next[0] ? '0 : hi;
    low_next[0] = dividend[QUO_W-1:0];
    qb_next[0]  = '0;
    for (int j = 1; j <= QUO_W; j++) begin
      trial = {rem[j-1], low[j-1][QUO_W-j]};
      low_next[j] = low[j-1];
      ovb_next[j] = ovb[j-1];
      if (trial >= {1'b0, divisor}) begin
        rem_next[j] = DIV_W'(trial - {1'b0, divisor});
        qb_next[j]  = qb[j-1] | (QUO_W'(1) << (QUO_W - j));
      end else begin
        rem_next[j] = DIV_W'(trial);
        qb_next[j]  = qb[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      low <= low_next;
      qb  <= qb_next;
      ovb <= ovb_next;
    end
  end

  assign quo = qb[QUO_W];
  assign ovf = ovb[QUO_W];
endmodule
`default_nettype wire

@@ hw/rtl/sfn_tanh.sv @@
// Table tanh with linear interpolation, four stages, odd symmetry.
// Depends on sfn_pkg; knots are built at elaboration.
`default_nettype none
module sfn_tanh #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [sfn_pkg::SQ_W-1:0] quo,
  input  logic                     ovf,
  input  logic                     neg,
  output logic signed [17:0]       coord
);
  import sfn_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int PW = SQ_W + IW;

  typedef logic [16:0] knot_t [DEPTH];

  // shift-subtract quotient, used only while the knots are built
  function automatic logic [63:0] knot_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, rm;
    q  = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[62:0], n[b]};
      if (rm >= d) begin
        rm   = rm - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic knot_t build_knots();
    knot_t      tab;
    logic [63:0] term, r, e, Num, Den;
    bit          stop;
    term = Q31_ONE;
    r    = Q31_ONE;
    e    = Q31_ONE;
    stop = 1'b0;
    // e^(-16/DEPTH) by the alternating series
    for (int N = 1; N < 64; N++) begin
      if (!stop) begin
        term = knot_div(term * 64'd16, 64'(DEPTH) * 64'(N));
        if (term == 0) stop = 1'b1;
        else if (N % 2 == 1) r = r - term;
        else r = r + term;
      end
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (k > 0) e = (e * r) >> 31;
      Num = (Q31_ONE - e) << 17;
      Den = Q31_ONE + e;
      tab[k] = 17'(knot_div(Num + Den, 64'd2 * Den));
    end
    return tab;
  endfunction

  localparam knot_t KNOTS = build_knots();

  logic [PW-1:0]   p1;
  logic            sat1, neg1;
  logic [16:0]     lo2, dif2;
  logic [SQ_W-1:0] f2;
  logic            sat2, neg2;
  logic [16:0]     lo3, frac3;
  logic            sat3, neg3;

  logic [IW-1:0]   idx1;
  logic [16:0]     lo_c, hi_c, mag_c;
  logic [35:0]     prod_c;

  always_comb begin
    idx1 = p1[PW-1:SQ_W];
    lo_c = KNOTS[idx1];
    hi_c = (idx1 == IW'(DEPTH - 1)) ? ONE_Q16 : KNOTS[IW'(idx1 + 1'b1)];
    if (hi_c < lo_c) hi_c = lo_c;
    prod_c = 36'(dif2) * 36'(f2);
    mag_c  = sat3 ? ONE_Q16 : 17'(lo3 + frac3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= PW'(PW'(quo) * PW'(DEPTH));
      sat1  <= ovf;
      neg1  <= neg;
      lo2   <= lo_c;
      dif2  <= 17'(hi_c - lo_c);
      f2    <= p1[SQ_W-1:0];
      sat2  <= sat1;
      neg2  <= neg1;
      lo3   <= lo2;
      frac3 <= prod_c[35:19];
      sat3  <= sat2;
      neg3  <= neg2;
      coord <= neg3 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end
endmodule
`default_nettype wire

@@ tb/segment_feature_normalizer_top_tb.sv @@
// Self-checking testbench for the segment feature normalizer top level.
// Depends on sfn_pkg and segment_feature_normalizer_top; uses no other file directly.
// Drives segment transactions and APB writes, and checks every point field.
module segment_feature_normalizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfn_pkg::*;

  localparam int KNOTS = 256;
  localparam int IDX_W = 16;

  typedef struct {
    bit [23:0]        open_bin;
    bit signed [31:0] score;
    bit signed [31:0] global_z;
    bit [15:0]        point_number;
  } segment_t;

  typedef struct {
    bit signed [31:0] time_coord;
    bit signed [31:0] score_coord;
    bit signed [31:0] magnitude_coord;
    bit [15:0]        point_index;
  } point_t;

  // Scoreboard: its own copy of the registers and the tanh knots, and the
  // queue of points still awaited from the block.
  class point_scoreboard;
    longint unsigned tanh_knots[KNOTS];
    bit [15:0] bin_ms;
    bit [31:0] duration_ms, score_scale, magnitude_scale;
    bit signed [15:0] time_weight, score_weight, magnitude_weight;
    point_t awaited_points[$];
    int errors;
    int points_checked;

    function new();
      longint unsigned term, ratio, e, num, den;
      term = 64'h8000_0000;
      ratio = term;
      e = term;
      for (int n = 1; n < 64; n++) begin
        term = (term * 16) / (KNOTS * n);
        if (term == 0) break;
        if (n % 2) ratio -= term;
        else ratio += term;
      end
      for (int k = 0; k < KNOTS; k++) begin
        if (k > 0) e = (e * ratio) >> 31;
        num = (64'h8000_0000 - e) << 17;
        den = 64'h8000_0000 + e;
        tanh_knots[k] = (num + den) / (2 * den);
      end
      bin_ms = 100;
      duration_ms = 1000;
      score_scale = 65536;
      magnitude_scale = 65536;
      time_weight = 4096;
      score_weight = 4096;
      magnitude_weight = 4096;
      errors = 0;
      points_checked = 0;
    endfunction

    function void set_reg(sfn_reg_t r, bit [31:0] v);
      case (r)
        REG_BIN_MS:       bin_ms = v[15:0];
        REG_DURATION_MS:  duration_ms = v;
        REG_SCORE_SCALE:  score_scale = v;
        REG_MAG_SCALE:    magnitude_scale = v;
        REG_TIME_WEIGHT:  time_weight = v[15:0];
        REG_SCORE_WEIGHT: score_weight = v[15:0];
        REG_MAG_WEIGHT:   magnitude_weight = v[15:0];
        default: ;
      endcase
    endfunction

    // tanh(mag/scale) in Q16.16, magnitude only
    function longint tanh_q16(longint unsigned mag, bit [31:0] scale);
      longint unsigned div, x, p, i, f, lo, hi;
      div = (scale == 0) ? 1 : scale;
      x = (mag << 16) / div;
      if (x >= 524288) return 65536;
      p = x * KNOTS;
      i = p >> 19;
      f = p & 524287;
      lo = tanh_knots[i];
      hi = (i + 1 < KNOTS) ? tanh_knots[i + 1] : 65536;
      if (hi < lo) hi = lo;
      return lo + (((hi - lo) * f) >> 19);
    endfunction

    // floor(c*w/4096), saturated to 32 bits
    function bit [31:0] weighted(longint c, bit signed [15:0] w);
      longint q;
      q = (c * longint'(w)) >>> 12;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function void note_segment(segment_t s);
      longint unsigned dur, t;
      longint sv, zv, sc;
      point_t pt;
      dur = (duration_ms == 0) ? 1 : duration_ms;
      t = ((longint'(s.open_bin) * bin_ms) << 16) / dur;
      if (t > (64'd1 << 44)) t = 64'd1 << 44;
      sv = s.score;
      zv = s.global_z;
      if (sv < 0) sc = -tanh_q16(-sv, score_scale);
      else if (sv > 0) sc = tanh_q16(sv, score_scale);
      else sc = 0;
      pt.time_coord = weighted(t, time_weight);
      pt.score_coord = weighted(sc, score_weight);
      pt.magnitude_coord = weighted(tanh_q16(zv < 0 ? -zv : zv, magnitude_scale),
                                    magnitude_weight);
      pt.point_index = s.point_number;
      awaited_points.push_back(pt);
    endfunction

    function void check_point(point_t got);
      point_t exp_pt;
      if (awaited_points.size() == 0) begin
        $error("point with no segment awaiting it: index %0d", got.point_index);
        errors++;
        return;
      end
      exp_pt = awaited_points.pop_front();
      points_checked++;
      if (got.time_coord !== exp_pt.time_coord) begin
        $error("time_coord: expected %0d, actual %0d", exp_pt.time_coord, got.time_coord);
        errors++;
      end
      if (got.score_coord !== exp_pt.score_coord) begin
        $error("score_coord: expected %0d, actual %0d", exp_pt.score_coord,
               got.score_coord);
        errors++;
      end
      if (got.magnitude_coord !== exp_pt.magnitude_coord) begin
        $error("magnitude_coord: expected %0d, actual %0d", exp_pt.magnitude_coord,
               got.magnitude_coord);
        errors++;
      end
      if (got.point_index !== exp_pt.point_index) begin
        $error("point_index: expected %0d, actual %0d", exp_pt.point_index,
               got.point_index);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;   // open_bin, score, global_z, point_number (low bit up)
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;   // time_coord, score_coord, magnitude_coord, point_index
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  point_scoreboard sb;
  bit quiet;          // no idling on either side once set
  bit long_hold_req;  // ask the receiver for one long hold-off
  int segments_sent;

  segment_feature_normalizer_top #(
    .TANH_TABLE_DEPTH(KNOTS),
    .INDEX_WIDTH(IDX_W)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("Verification failed");
    $finish;
  end

  // Monitor both handshakes at the edge; note the segment before checking,
  // since a point can never leave in the cycle its segment enters.
  always @(posedge clk) begin
    point_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_segment('{s_tdata[23:0], s_tdata[55:24], s_tdata[87:56],
                          s_tdata[103:88]});
        segments_sent++;
      end
      if (m_tvalid && m_tready) begin
        got.time_coord = m_tdata[31:0];
        got.score_coord = m_tdata[63:32];
        got.magnitude_coord = m_tdata[95:64];
        got.point_index = m_tdata[111:96];
        sb.check_point(got);
      end
    end
  end

  // Receiver: ready stretches, short stalls, and one long hold-off on request
  // so the pipeline fills and pushes back on the sender.
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // APB write: setup, access, then release the bus.
  task automatic write_reg(sfn_reg_t r, bit [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic load_config(bit [15:0] bms, bit [31:0] dur, bit [31:0] ss,
                             bit [31:0] ms, bit [15:0] tw, bit [15:0] sw,
                             bit [15:0] mw);
    write_reg(REG_BIN_MS, bms);
    write_reg(REG_DURATION_MS, dur);
    write_reg(REG_SCORE_SCALE, ss);
    write_reg(REG_MAG_SCALE, ms);
    write_reg(REG_TIME_WEIGHT, tw);
    write_reg(REG_SCORE_WEIGHT, sw);
    write_reg(REG_MAG_WEIGHT, mw);
  endtask

  // Offer one segment, with an optional gap first; return after the edge
  // that accepts it.
  task automatic send_segment(segment_t s);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {s.point_number, s.global_z, s.score, s.open_bin};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic bit [31:0] pick_q16();
    bit [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = $urandom_range(0, 600000);
      2: v = $urandom_range(0, 70000);
      3: v = $urandom_range(0, 2) == 0 ? 32'h8000_0000 :
             ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0);
      default: v = $urandom_range(0, 10000000);
    endcase
    if ($urandom_range(0, 1) && $urandom_range(0, 4) != 3) v = -v;
    return v;
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    case ($urandom_range(0, 3))
      0: s.open_bin = $urandom_range(0, 24'hFF_FFFF);
      1: s.open_bin = $urandom_range(0, 1000);
      2: s.open_bin = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
      default: s.open_bin = $urandom_range(0, 100000);
    endcase
    s.score = pick_q16();
    s.global_z = pick_q16();
    s.point_number = $urandom_range(0, 16'hFFFF);
    return s;
  endfunction

  function automatic bit [31:0] random_scale();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(1000, 1 << 20);
      3: return $urandom();
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  task automatic run_random(int count);
    repeat (count) send_segment(random_segment());
    s_tvalid <= 1'b0;
    while (sb.awaited_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    segment_t directed[$];
    sb = new();
    quiet = 1'b0;
    long_hold_req = 1'b0;
    segments_sent = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero and negative score, tanh saturation,
    // the interpolation range and the top knot, under reset settings.
    directed = '{
      '{24'd0, 32'sd0, 32'sd0, 16'd0},
      '{24'hFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF},
      '{24'd1, -32'sh8000_0000, -32'sh8000_0000, 16'h8000},
      '{24'd10, 32'sd1, -32'sd1, 16'd1},
      '{24'd5, -32'sd1, 32'sd1, 16'd2},
      '{24'd7, 32'sd65536, -32'sd65536, 16'd3},
      '{24'd9, -32'sd65536, 32'sd131072, 16'd4},
      '{24'd100, 32'sd524287, -32'sd524287, 16'd5},
      '{24'd100, 32'sd524288, 32'sd524288, 16'd6},
      '{24'd1000, -32'sd524288, -32'sd524289, 16'd7},
      '{24'd12345, 32'sd522240, 32'sd2048, 16'd8},
      '{24'h80_0000, -32'sd522241, 32'sd30000, 16'h5555},
      '{24'h7F_FFFF, 32'sd12345, -32'sd98765, 16'hAAAA},
      '{24'd3, 32'sd32768, 32'sd0, 16'h00FF},
      '{24'd4, -32'sd32768, 32'sd0, 16'hFF00},
      '{24'h55_5555, 32'sh5555_5555, -32'sh5555_5555, 16'd9},
      '{24'hAA_AAAA, -32'sh2AAA_AAAA, 32'sh2AAA_AAAA, 16'd10}
    };
    foreach (directed[i]) send_segment(directed[i]);
    s_tvalid <= 1'b0;
    while (sb.awaited_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    // Zero bin width, zero divisors, largest positive weights; the receiver
    // holds off long enough for the block to push back.
    load_config(16'd0, 32'd0, 32'd0, 32'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    long_hold_req = 1'b1;
    run_random(200);

    // Largest settings and most negative weights.
    load_config(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'h8000, 16'h8000, 16'h8000);
    run_random(200);

    // Score weight -1, magnitude weight 0, rest 1; small divisors push time hard.
    load_config(16'd1, 32'd1, 32'd1, 32'd1, 16'd1, 16'hFFFF, 16'd0);
    run_random(150);

    repeat (3) begin
      load_config($urandom_range(0, 3) == 0 ? 16'd1 : 16'($urandom_range(0, 65535)),
                  $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000),
                  random_scale(), random_scale(), 16'($urandom()),
                  16'($urandom()), 16'($urandom()));
      run_random(200);
    end

    // Closing stretch at reset settings with both sides always ready.
    load_config(16'd100, 32'd1000, 32'd65536, 32'd65536, 16'd4096, 16'd4096,
                16'd4096);
    quiet = 1'b1;
    run_random(180);

    repeat (60) @(posedge clk);
    $display("Run covered %0d segments and %0d checked points across eight settings,",
             segments_sent, sb.points_checked);
    $display("including zero and full-scale divisors, weights and long back-pressure.");
    if (sb.errors == 0 && sb.awaited_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.awaited_points.size() != 0)
        $error("%0d points never arrived", sb.awaited_points.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
